// File: src/row_box_blur_edge_clamped_unit_defines.svh
// Assertion macros of the box blur RTL.
// No dependencies; the top level, which checks its logic, includes this header.
`ifndef ROW_BOX_BLUR_EDGE_CLAMPED_UNIT_DEFINES_SVH
`define ROW_BOX_BLUR_EDGE_CLAMPED_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define BBC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define BBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BBC_ASSERT_IMP(lbl, ante, cons, msg)
`define BBC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: src/bbc_pkg.sv
// Types, constants and register map of the row box blur.
// No dependencies.
package bbc_pkg;
    localparam int CHANNELS          = 4;
    localparam int SUM_W             = 16;
    localparam int CHAN_W            = 8;
    localparam int RADIUS_REG_W      = 6;
    localparam int DIM_REG_W         = 13;
    localparam int MAX_RADIUS_DEF    = 63;
    localparam int MAX_ROW_WIDTH_DEF = 4096;
    localparam int PADDR_W           = 4;
    localparam int PDATA_W           = 32;

    localparam logic [RADIUS_REG_W-1:0] RADIUS_RST = RADIUS_REG_W'(1);
    localparam logic [DIM_REG_W-1:0]    WIDTH_RST  = DIM_REG_W'(640);
    localparam logic [DIM_REG_W-1:0]    ROWS_RST   = DIM_REG_W'(480);

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_ROWS   = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha_in;
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] red_in;
    } pix_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic [CHAN_W-1:0] alpha_out;
        logic              last_of_run;
        logic              row_end;
        logic              image_end;
        logic              blur_skipped;
    } res_t;

    typedef logic [CHANNELS-1:0][SUM_W-1:0]  sums_t;
    typedef logic [CHANNELS-1:0][CHAN_W-1:0] quot_t;

    typedef struct packed {
        logic  done;
        quot_t quot;
    } div_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_UPD,
        S_GO,
        S_DIV,
        S_OUT,
        S_TRD,
        S_TUPD
    } state_t;
endpackage

// File: src/row_box_blur_edge_clamped_unit.sv
// Row box blur, RGBA, edge pixels replicated. One pixel at a time: a blurred result is
// presented after its pixel beat passes the store read, sum update, divider start and
// the serial divide; at a row end each of the radius trailing results repeats the read,
// update, start and divide before its beat. Pixels with no result only read and update;
// pass-through pixels go straight to the output. An output stall holds the unit.
// Reset clears sums and counters and loads the config defaults.
`include "row_box_blur_edge_clamped_unit_defines.svh"
module row_box_blur_edge_clamped_unit
    import bbc_pkg::*;
#(
    parameter int MAX_RADIUS    = MAX_RADIUS_DEF,
    parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               pix_valid,
    output logic               pix_ready,
    input  pix_t               pix,
    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res
);
    localparam int ADDR_W = $clog2(2 * MAX_RADIUS + 2);
    localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
    localparam int DIV_W  = RAD_W + 1;
    localparam int CNT_W  = $clog2(MAX_ROW_WIDTH + 1);
    localparam int REXT_W = (RAD_W > RADIUS_REG_W) ? RAD_W : RADIUS_REG_W;
    localparam int WEXT_W = (CNT_W > DIM_REG_W) ? CNT_W : DIM_REG_W;
    localparam int CMP_W  = ((CNT_W > DIV_W) ? CNT_W : DIV_W) + 1;

    // configuration
    logic [RADIUS_REG_W-1:0] radius_reg;
    logic [DIM_REG_W-1:0]    width_reg;
    logic [DIM_REG_W-1:0]    rows_reg;
    logic                    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            width_reg  <= WIDTH_RST;
            rows_reg   <= ROWS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_RADIUS: radius_reg <= pwdata[RADIUS_REG_W-1:0];
                REG_WIDTH:  width_reg  <= pwdata[DIM_REG_W-1:0];
                REG_ROWS:   rows_reg   <= pwdata[DIM_REG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_RADIUS: prdata = PDATA_W'(radius_reg);
            REG_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_ROWS:   prdata = PDATA_W'(rows_reg);
            default:    prdata = '0;
        endcase
    end

    // row state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   col_reg;
    logic [DIM_REG_W-1:0] row_reg;
    logic [RAD_W-1:0]   hrad_reg;
    logic [CNT_W-1:0]   hwid_reg;
    logic [CNT_W-1:0]   c_reg;
    logic [31:0]        px_reg;
    logic [31:0]        first_reg;
    sums_t              sum_reg;
    logic               skip_reg;
    logic               last_col_reg;
    logic               last_row_reg;
    logic [RAD_W-1:0]   tail_cnt_reg;
    logic [ADDR_W-1:0]  tail_addr_reg;
    res_t               res_reg;

    logic [REXT_W-1:0]  rad_ext;
    logic [WEXT_W-1:0]  wid_ext;
    logic [RAD_W-1:0]   rad_fresh;
    logic [CNT_W-1:0]   wid_fresh;
    logic [RAD_W-1:0]   rad_eff;
    logic [CNT_W-1:0]   wid_eff;
    logic [DIV_W-1:0]   d_eff;
    logic [DIV_W-1:0]   d_held;
    logic [DIM_REG_W:0] rows_eff;
    logic               last_col_now;
    logic               last_row_now;
    logic               skip_now;
    logic               accept;

    always_comb
    begin
        rad_ext   = REXT_W'(radius_reg);
        wid_ext   = WEXT_W'(width_reg);
        rad_fresh = (rad_ext > REXT_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : RAD_W'(rad_ext);
        if (wid_ext == '0)
        begin
            wid_fresh = CNT_W'(1);
        end
        else if (wid_ext > WEXT_W'(MAX_ROW_WIDTH))
        begin
            wid_fresh = CNT_W'(MAX_ROW_WIDTH);
        end
        else
        begin
            wid_fresh = CNT_W'(wid_ext);
        end
        rad_eff  = (col_reg == '0) ? rad_fresh : hrad_reg;
        wid_eff  = (col_reg == '0) ? wid_fresh : hwid_reg;
        d_eff    = {rad_eff, 1'b1};
        rows_eff = (rows_reg == '0) ? (DIM_REG_W + 1)'(1) : {1'b0, rows_reg};
        skip_now = CMP_W'(wid_eff) <= CMP_W'(d_eff);
        last_col_now = (CMP_W'(col_reg) + CMP_W'(1)) >= CMP_W'(wid_eff);
        last_row_now = last_col_now && (({1'b0, row_reg} + 1'b1) >= rows_eff);
    end

    assign d_held = {hrad_reg, 1'b1};
    assign accept = pix_valid && pix_ready;

    // window store and divider
    logic              mem_we;
    logic [ADDR_W-1:0] mem_raddr;
    logic [31:0]       mem_rdata;
    logic              div_start;
    div_rsp_t          div_rsp;

    bbc_window_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (c_reg[ADDR_W-1:0]),
        .wdata (px_reg),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bbc_divider #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (d_held),
        .rsp      (div_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pix_valid)
                begin
                    state_next = skip_now ? S_OUT : S_RD;
                end
            end
            S_RD:   state_next = S_UPD;
            S_UPD:
            begin
                state_next = (CMP_W'(c_reg) >= CMP_W'(hrad_reg)) ? S_GO : S_IDLE;
            end
            S_GO:   state_next = S_DIV;
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = (tail_cnt_reg != '0) ? S_TRD : S_IDLE;
                end
            end
            S_TRD:  state_next = S_TUPD;
            S_TUPD: state_next = S_GO;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        pix_ready = 1'b0;
        res_valid = 1'b0;
        mem_we    = 1'b0;
        div_start = 1'b0;
        mem_raddr = c_reg[ADDR_W-1:0] - d_held[ADDR_W-1:0];
        unique case (state_reg)
            S_IDLE: pix_ready = 1'b1;
            S_RD:   mem_we    = 1'b1;
            S_GO:   div_start = 1'b1;
            S_OUT:  res_valid = 1'b1;
            S_TRD:  mem_raddr = tail_addr_reg;
            default: ;
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            col_reg      <= '0;
            row_reg      <= '0;
            hrad_reg     <= RAD_W'(1);
            hwid_reg     <= CNT_W'(640);
            first_reg    <= '0;
            sum_reg      <= '0;
            tail_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                hrad_reg     <= rad_eff;
                hwid_reg     <= wid_eff;
                tail_cnt_reg <= '0;
                if (last_col_now)
                begin
                    col_reg <= '0;
                    row_reg <= last_row_now ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (state_reg == S_UPD)
            begin
                if (c_reg == '0)
                begin
                    first_reg <= px_reg;
                    for (int k = 0; k < CHANNELS; k++)
                    begin
                        sum_reg[k] <= SUM_W'(d_held) * SUM_W'(px_reg[k*CHAN_W +: CHAN_W]);
                    end
                end
                else
                begin
                    for (int k = 0; k < CHANNELS; k++)
                    begin
                        logic [31:0] old_px;
                        old_px = (CMP_W'(c_reg) >= CMP_W'(d_held)) ? mem_rdata : first_reg;
                        sum_reg[k] <= sum_reg[k] + SUM_W'(px_reg[k*CHAN_W +: CHAN_W])
                                      - SUM_W'(old_px[k*CHAN_W +: CHAN_W]);
                    end
                end
                if (last_col_reg)
                begin
                    tail_cnt_reg <= hrad_reg;
                end
            end
            if (state_reg == S_TUPD)
            begin
                tail_cnt_reg <= tail_cnt_reg - 1'b1;
                for (int k = 0; k < CHANNELS; k++)
                begin
                    sum_reg[k] <= sum_reg[k] + SUM_W'(px_reg[k*CHAN_W +: CHAN_W])
                                  - SUM_W'(mem_rdata[k*CHAN_W +: CHAN_W]);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg       <= pix;
            c_reg        <= col_reg;
            skip_reg     <= skip_now;
            last_col_reg <= last_col_now;
            last_row_reg <= last_row_now;
            if (skip_now)
            begin
                res_reg.red_out      <= pix.red_in;
                res_reg.green_out    <= pix.green_in;
                res_reg.blue_out     <= pix.blue_in;
                res_reg.alpha_out    <= pix.alpha_in;
                res_reg.last_of_run  <= 1'b1;
                res_reg.row_end      <= last_col_now;
                res_reg.image_end    <= last_row_now;
                res_reg.blur_skipped <= 1'b1;
            end
        end
        if (state_reg == S_UPD)
        begin
            // first trailing sample drops pixel w-2r-1
            tail_addr_reg <= hwid_reg[ADDR_W-1:0] - d_held[ADDR_W-1:0];
        end
        if (state_reg == S_TUPD)
        begin
            tail_addr_reg <= tail_addr_reg + 1'b1;
        end
        if (state_reg == S_DIV && div_rsp.done)
        begin
            res_reg.red_out      <= div_rsp.quot[0];
            res_reg.green_out    <= div_rsp.quot[1];
            res_reg.blue_out     <= div_rsp.quot[2];
            res_reg.alpha_out    <= div_rsp.quot[3];
            res_reg.last_of_run  <= (tail_cnt_reg == '0);
            res_reg.row_end      <= (tail_cnt_reg == '0) && last_col_reg;
            res_reg.image_end    <= (tail_cnt_reg == '0) && last_row_reg;
            res_reg.blur_skipped <= 1'b0;
        end
    end

    `BBC_ASSERT_IMP(a_idle_no_result, pix_ready, !res_valid, "result pending while idle")
    `BBC_ASSERT_NXT(a_div_to_out, (state_reg == S_DIV) && div_rsp.done, res_valid,
                    "divider result not presented")
    `BBC_ASSERT_IMP(a_tail_on_row_end, tail_cnt_reg != '0, last_col_reg && !skip_reg,
                    "trailing outputs outside a row end")
    `BBC_ASSERT_IMP(a_start_not_idle, div_start, state_reg == S_GO, "stray divider start")
endmodule

// File: src/bbc_window_mem.sv
// Ring store of recent pixels: one write port, one registered read port.
// Depends on bbc_pkg.
module bbc_window_mem
    import bbc_pkg::*;
#(
    parameter int ADDR_W = 7
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [31:0]       wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [31:0]       rdata
);
    logic [31:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/bbc_divider.sv
// Four-lane restoring divider, one quotient bit per cycle.
// Depends on bbc_pkg; the top level includes the assertion macros.
module bbc_divider
    import bbc_pkg::*;
#(
    parameter int DIV_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  sums_t            dividend,
    input  logic [DIV_W-1:0] divisor,
    output div_rsp_t         rsp
);
    localparam int CNT_W = $clog2(SUM_W);

    logic                      busy_reg;
    logic                      done_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [DIV_W-1:0]          dvs_reg;
    logic [CHANNELS-1:0][DIV_W-1:0] rem_reg;
    sums_t                     quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= divisor;
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                logic [DIV_W:0] trial;
                trial = {rem_reg[k], quo_reg[k][SUM_W-1]};
                if (trial >= {1'b0, dvs_reg})
                begin
                    rem_reg[k] <= DIV_W'(trial - {1'b0, dvs_reg});
                    quo_reg[k] <= {quo_reg[k][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= trial[DIV_W-1:0];
                    quo_reg[k] <= {quo_reg[k][SUM_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        for (int k = 0; k < CHANNELS; k++)
        begin
            rsp.quot[k] = quo_reg[k][CHAN_W-1:0];
        end
    end
endmodule
